// ===== src/dps_pkg.sv =====
`timescale 1ns / 1ps

package dps_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int QCOUNT_W      = 5;

    localparam logic signed [7:0] PRI_MIN = -8'sd128;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_FULL      = 3'd1,
        ST_ZERO_TIME = 3'd2,
        ST_REQUEUED  = 3'd3,
        ST_FINISHED  = 3'd4,
        ST_IDLE      = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_CHECK,
        S_INSERT,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t                operation;
        logic [7:0]         proc_id;
        logic signed [7:0]  start_priority;
        logic [15:0]        run_time;
    } request_t;

    typedef struct packed {
        status_t               status;
        logic [7:0]            ran_id;
        logic signed [7:0]     ran_priority;
        logic [15:0]           remaining_time;
        logic [QCOUNT_W-1:0]   queue_count;
    } result_t;

    typedef struct packed {
        logic    load_item;
        logic    load_head;
        logic    drop;
        logic    insert;
        logic    res_load;
        logic    res_ran;
        status_t res_status;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic time_zero;
        logic full;
        logic empty;
    } dp_flags_t;

endpackage

// ===== src/dynamic_priority_scheduler.sv =====
`timescale 1ns / 1ps

// Priority scheduler with aging over a sorted row of DEPTH entries, highest
// priority at the head, equal priorities first in, first out. The result is loaded
// after the states decide and done for a rejected add or an idle tick; decide,
// insert and done for a stored add; decide, check and done for a finished tick;
// and decide, check, insert and done for a requeued tick, with one shift of the
// entry row per step (drop the head, then insert in place). One item is in work at
// a time. The next is accepted the cycle after the result is loaded into the
// output register. A result still held by a stalled consumer delays the next write
// into that register, and with it the acceptance of the item after that.

module dynamic_priority_scheduler
    import dps_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     request_valid,
    output logic     request_stall,
    input  request_t request,
    output logic     result_valid,
    input  logic     result_stall,
    output result_t  result
);

    dp_cmd_t   cmd;
    dp_flags_t flags;

    dps_controller u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .flags         (flags),
        .cmd           (cmd)
    );

    dps_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .flags   (flags),
        .result  (result)
    );

    a_finished_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_FINISHED |-> result.remaining_time == 16'd0)
        else $error("finished item with time left");

    a_requeued_left: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_REQUEUED |-> result.remaining_time != 16'd0)
        else $error("requeued item with no time left");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(request_stall))
        else $error("result without item in work");

    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> !flags.full)
        else $error("insert into full row");

endmodule

// ===== src/dps_datapath.sv =====
`timescale 1ns / 1ps

module dps_datapath
    import dps_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  dp_cmd_t   cmd,
    input  request_t  request,
    output dp_flags_t flags,
    output result_t   result
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]        id_reg   [DEPTH];
    logic signed [7:0] pri_reg  [DEPTH];
    logic [15:0]       time_reg [DEPTH];
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    op_t               op_reg;
    logic [7:0]        w_id_reg;
    logic signed [7:0] w_pri_reg;
    logic [15:0]       w_time_reg;
    result_t           res_reg;

    logic [DEPTH-1:0]  ge;
    logic signed [7:0] head_pri_dec;
    logic [15:0]       head_time_dec;

    assign head_pri_dec  = (pri_reg[0] == PRI_MIN) ? pri_reg[0] : pri_reg[0] - 8'sd1;
    assign head_time_dec = (time_reg[0] == 16'd0) ? 16'd0 : time_reg[0] - 16'd1;

    // sorted row: cell k keeps its entry while its priority is >= the new one
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic              prev_ge;
        logic [7:0]        up_id;
        logic signed [7:0] up_pri;
        logic [15:0]       up_time;
        logic [7:0]        dn_id;
        logic signed [7:0] dn_pri;
        logic [15:0]       dn_time;

        if (k == 0) begin : g_first
            assign prev_ge = 1'b1;
            assign up_id   = w_id_reg;
            assign up_pri  = w_pri_reg;
            assign up_time = w_time_reg;
        end
        else begin : g_rest
            assign prev_ge = ge[k-1];
            assign up_id   = id_reg[k-1];
            assign up_pri  = pri_reg[k-1];
            assign up_time = time_reg[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign dn_id   = id_reg[k];
            assign dn_pri  = pri_reg[k];
            assign dn_time = time_reg[k];
        end
        else begin : g_inner
            assign dn_id   = id_reg[k+1];
            assign dn_pri  = pri_reg[k+1];
            assign dn_time = time_reg[k+1];
        end

        assign ge[k] = (CW'(k) < count_reg) && (pri_reg[k] >= w_pri_reg);

        always_ff @(posedge clk)
        begin
            if (cmd.drop)
            begin
                id_reg[k]   <= dn_id;
                pri_reg[k]  <= dn_pri;
                time_reg[k] <= dn_time;
            end
            else if (cmd.insert && !ge[k])
            begin
                if (prev_ge)
                begin
                    id_reg[k]   <= w_id_reg;
                    pri_reg[k]  <= w_pri_reg;
                    time_reg[k] <= w_time_reg;
                end
                else
                begin
                    id_reg[k]   <= up_id;
                    pri_reg[k]  <= up_pri;
                    time_reg[k] <= up_time;
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.drop)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (cmd.insert)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg     <= request.operation;
            w_id_reg   <= request.proc_id;
            w_pri_reg  <= request.start_priority;
            w_time_reg <= request.run_time;
        end
        else if (cmd.load_head)
        begin
            w_id_reg   <= id_reg[0];
            w_pri_reg  <= head_pri_dec;
            w_time_reg <= head_time_dec;
        end
        if (cmd.res_load)
        begin
            res_reg.status      <= cmd.res_status;
            res_reg.queue_count <= QCOUNT_W'(count_reg);
            if (cmd.res_ran)
            begin
                res_reg.ran_id         <= w_id_reg;
                res_reg.ran_priority   <= w_pri_reg;
                res_reg.remaining_time <= w_time_reg;
            end
            else
            begin
                res_reg.ran_id         <= '0;
                res_reg.ran_priority   <= '0;
                res_reg.remaining_time <= '0;
            end
        end
    end

    assign flags.op        = op_reg;
    assign flags.time_zero = (w_time_reg == 16'd0);
    assign flags.full      = (count_reg == CW'(DEPTH));
    assign flags.empty     = (count_reg == '0);
    assign result          = res_reg;

endmodule

// ===== src/dps_controller.sv =====
`timescale 1ns / 1ps

module dps_controller
    import dps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      request_valid,
    output logic      request_stall,
    output logic      result_valid,
    input  logic      result_stall,
    input  dp_flags_t flags,
    output dp_cmd_t   cmd
);

    state_t  state_reg;
    state_t  state_next;
    status_t st_reg;
    status_t st_next;
    logic    out_valid_reg;
    logic    out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg && result_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (request_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (flags.op == OP_ADD)
                begin
                    if (flags.time_zero)
                    begin
                        st_next    = ST_ZERO_TIME;
                        state_next = S_DONE;
                    end
                    else if (flags.full)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        st_next    = ST_ADDED;
                        state_next = S_INSERT;
                    end
                end
                else if (flags.empty)
                begin
                    st_next    = ST_IDLE;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (flags.time_zero)
                begin
                    st_next    = ST_FINISHED;
                    state_next = S_DONE;
                end
                else
                begin
                    st_next    = ST_REQUEUED;
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.res_status = st_reg;
        cmd.res_ran    = (st_reg == ST_FINISHED) || (st_reg == ST_REQUEUED);
        request_stall  = (state_reg != S_IDLE);
        result_valid   = out_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_item = request_valid;
            end
            S_DECIDE:
            begin
                if (flags.op == OP_TICK && !flags.empty)
                begin
                    cmd.load_head = 1'b1;
                    cmd.drop      = 1'b1;
                end
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
            end
            S_DONE:
            begin
                cmd.res_load = !out_valid_reg || !result_stall;
            end
            default:
            begin
                cmd.res_load = 1'b0;
            end
        endcase
    end

endmodule
